// ===== hdl/pidc_pkg.sv =====
// Shared types, constants and helper functions for the PID controller step block.
// Used by the controller, the datapath, the serial divider and the top level.
`default_nettype none

package pidc_pkg;

  localparam int unsigned WORD_W = 32;
  localparam int unsigned DT_W   = 24;
  localparam int unsigned LIM_W  = 31;
  localparam int unsigned IDX_W  = 2;
  localparam int unsigned MAG_W  = WORD_W + 1;
  localparam int unsigned PROD_W = 2 * WORD_W;
  localparam int unsigned PMAG_W = PROD_W - 16;
  localparam int unsigned INC_W  = 57;
  localparam int unsigned DCAP_W = 57;
  localparam int unsigned WIDE_W = 60;

  localparam logic [IDX_W-1:0] CFG_GAIN_P  = 2'd0;
  localparam logic [IDX_W-1:0] CFG_GAIN_I  = 2'd1;
  localparam logic [IDX_W-1:0] CFG_GAIN_D  = 2'd2;
  localparam logic [IDX_W-1:0] CFG_WINDUP  = 2'd3;

  localparam logic [LIM_W-1:0] WINDUP_RESET = 31'd327680;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_PREP,
    ST_MUL_P,
    ST_MUL_I,
    ST_MUL_ILO,
    ST_MUL_IHI,
    ST_MUL_D,
    ST_ACC,
    ST_PSUM,
    ST_WAIT,
    ST_DTERM,
    ST_SUM,
    ST_FIN
  } pidc_state_e;

  typedef enum logic [2:0] {
    MUL_P,
    MUL_I,
    MUL_ILO,
    MUL_IHI,
    MUL_D
  } pidc_mul_e;

  typedef struct packed {
    logic [WORD_W-1:0] gain_p;
    logic [WORD_W-1:0] gain_i;
    logic [WORD_W-1:0] gain_d;
    logic [LIM_W-1:0]  windup;
  } pidc_cfg_t;

  typedef struct packed {
    logic      load;
    logic      prep;
    logic      mul_en;
    pidc_mul_e mul_sel;
    logic      p_cap;
    logic      ahi_cap;
    logic      lohi_cap;
    logic      inc_cap;
    logic      acc_cap;
    logic      div_start;
    logic      psum_cap;
    logic      dterm_cap;
    logic      sum_cap;
    logic      push;
  } pidc_cmd_t;

  typedef struct packed {
    logic dt_zero;
    logic div_busy;
    logic out_free;
  } pidc_sts_t;

  // Magnitude of a signed word as an unsigned word; the most negative value maps to 2^31.
  function automatic logic [WORD_W-1:0] mag_word(input logic [WORD_W-1:0] v);
    return v[WORD_W-1] ? (~v + {{(WORD_W-1){1'b0}}, 1'b1}) : v;
  endfunction

endpackage

`default_nettype wire

// ===== hdl/pid_controller_step.sv =====
// PID controller step with derivative on measurement and integral anti-windup clamp.
// Top level: configuration registers, controller and datapath. Uses pidc_pkg.
//
// Each input item (target, measured, elapsed) yields one result item (drive,
// integral_now). All values are signed Q16.16; elapsed is unsigned Q8.16 seconds.
// Gains and the windup limit are written through the cfg_we_i port; the user must
// write them only while idle, as the block does not enforce it. The block works on
// one item at a time. The result waits on the radix-4 serial divider that forms
// the derivative term; with zero elapsed time the division is skipped. A new item
// is accepted the cycle after the result enters the output register, so a result
// may wait there while the next item is worked on.
// If the receiver stalls and the output register is still full when the next result
// is ready, the block holds that result and keeps in_stall_o high.
// Reset clears the integral, the previous measurement and the gains and sets the
// windup limit to 5.0; no item is pending after reset.
`default_nettype none

module pid_controller_step
  import pidc_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              cfg_we_i,
  input  wire logic [IDX_W-1:0]  cfg_idx_i,
  input  wire logic [WORD_W-1:0] cfg_data_i,
  input  wire logic              in_valid_i,
  output logic                   in_stall_o,
  input  wire logic [WORD_W-1:0] target_i,
  input  wire logic [WORD_W-1:0] measured_i,
  input  wire logic [DT_W-1:0]   elapsed_i,
  output logic                   out_valid_o,
  input  wire logic              out_stall_i,
  output logic [WORD_W-1:0]      drive_o,
  output logic [WORD_W-1:0]      integral_now_o
);

  pidc_cfg_t cfg_q;
  pidc_cmd_t cmd;
  pidc_sts_t sts;
  logic      in_acc;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.gain_p <= '0;
      cfg_q.gain_i <= '0;
      cfg_q.gain_d <= '0;
      cfg_q.windup <= WINDUP_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_GAIN_P: cfg_q.gain_p <= cfg_data_i;
        CFG_GAIN_I: cfg_q.gain_i <= cfg_data_i;
        CFG_GAIN_D: cfg_q.gain_d <= cfg_data_i;
        CFG_WINDUP: cfg_q.windup <= cfg_data_i[LIM_W-1:0];
        default: begin
        end
      endcase
    end
  end

  pidc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .cmd_o      (cmd),
    .sts_i      (sts)
  );

  pidc_dp u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_i          (cfg_q),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .target_i       (target_i),
    .measured_i     (measured_i),
    .elapsed_i      (elapsed_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .drive_o        (drive_o),
    .integral_now_o (integral_now_o)
  );

  assign in_acc = in_valid_i && !in_stall_o;

  // An accepted item keeps the block busy on the next cycle.
  a_busy_after_accept : assert property (
    @(posedge clk_i) disable iff (!rst_ni) in_acc |=> in_stall_o
  ) else $error("input taken while previous item still in progress");

  // A fresh result can only follow a cycle in which the block was busy.
  a_result_from_work : assert property (
    @(posedge clk_i) disable iff (!rst_ni) $rose(out_valid_o) |-> $past(in_stall_o)
  ) else $error("result appeared without an item in progress");

  // The reported integral always lies within the windup limit.
  a_integral_clamped : assert property (
    @(posedge clk_i) disable iff (!rst_ni)
      out_valid_o |->
        ($signed({integral_now_o[WORD_W-1], integral_now_o}) <=
           $signed({2'b00, cfg_q.windup})) &&
        ($signed({integral_now_o[WORD_W-1], integral_now_o}) >=
           -$signed({2'b00, cfg_q.windup}))
  ) else $error("integral outside the windup limit");

  // While the divider runs the datapath must not start a new item.
  a_div_idle_on_load : assert property (
    @(posedge clk_i) disable iff (!rst_ni) cmd.load |-> !sts.div_busy
  ) else $error("item loaded while the divider is busy");

endmodule

`default_nettype wire

// ===== hdl/pidc_div.sv =====
// Radix-4 restoring divider: 64-bit dividend by 24-bit divisor, two quotient bits a cycle.
// Depends on pidc_pkg for the word widths.
`default_nettype none

module pidc_div
  import pidc_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              start_i,
  input  wire logic [PROD_W-1:0] dividend_i,
  input  wire logic [DT_W-1:0]   divisor_i,
  output logic                   busy_o,
  output logic [PROD_W-1:0]      quotient_o
);

  localparam int unsigned STEPS = PROD_W / 2;
  localparam int unsigned CNT_W = $clog2(STEPS);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(STEPS - 1);

  logic              busy_q;
  logic [CNT_W-1:0]  cnt_q;
  logic [DT_W-1:0]   divisor_q;
  logic [DT_W-1:0]   rem_q, rem_d;
  logic [PROD_W-1:0] quo_q, quo_d;
  logic [DT_W:0]     trial;

  always_comb begin
    rem_d = rem_q;
    quo_d = quo_q;
    trial = '0;
    for (int k = 0; k < 2; k++) begin
      trial = {rem_d, quo_d[PROD_W-1]};
      quo_d = {quo_d[PROD_W-2:0], 1'b0};
      if (trial >= {1'b0, divisor_q}) begin
        rem_d    = DT_W'(trial - {1'b0, divisor_q});
        quo_d[0] = 1'b1;
      end else begin
        rem_d = trial[DT_W-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= '0;
    end else if (busy_q) begin
      cnt_q <= cnt_q + {{(CNT_W-1){1'b0}}, 1'b1};
      if (cnt_q == CNT_LAST) begin
        busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      divisor_q <= divisor_i;
      rem_q     <= '0;
      quo_q     <= dividend_i;
    end else if (busy_q) begin
      rem_q <= rem_d;
      quo_q <= quo_d;
    end
  end

  assign busy_o     = busy_q;
  assign quotient_o = quo_q;

endmodule

`default_nettype wire

// ===== hdl/pidc_dp.sv =====
// Datapath of the PID step: input latch, shared 32x32 multiplier, integral clamp,
// derivative divider, final sum with saturation, and the output register. Uses pidc_pkg.
`default_nettype none

module pidc_dp
  import pidc_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire pidc_cfg_t         cfg_i,
  input  wire pidc_cmd_t         cmd_i,
  output pidc_sts_t              sts_o,
  input  wire logic [WORD_W-1:0] target_i,
  input  wire logic [WORD_W-1:0] measured_i,
  input  wire logic [DT_W-1:0]   elapsed_i,
  output logic                   out_valid_o,
  input  wire logic              out_stall_i,
  output logic [WORD_W-1:0]      drive_o,
  output logic [WORD_W-1:0]      integral_now_o
);

  localparam logic [WIDE_W-1:0] SAT_HI = {{(WIDE_W-WORD_W+1){1'b0}}, {(WORD_W-1){1'b1}}};
  localparam logic [WIDE_W-1:0] SAT_LO = ~SAT_HI;
  localparam logic [PROD_W-1:0] DCAP   = PROD_W'(1) << (DCAP_W - 1);

  logic [WORD_W-1:0] target_q, measured_q;
  logic [DT_W-1:0]   elapsed_q;
  logic [WORD_W-1:0] integral_q, prev_q;
  logic [MAG_W-1:0]  em_q, em_d, dm_q, dm_d;
  logic              eneg_q, dneg_q;
  logic [MAG_W-1:0]  err_w, dfb_w;

  logic [WORD_W-1:0] op_a;
  logic [MAG_W-1:0]  op_b;
  logic [PROD_W-1:0] prod_w, mul_q;
  logic [PMAG_W-1:0] pmag_q;
  logic [WORD_W-1:0] ahi_q, lohi_q;
  logic [INC_W-1:0]  inc_q;

  logic [WIDE_W-1:0] inc_u, inc_w, acc_sum, lim_pos, lim_neg, acc_cl;
  logic [WORD_W-1:0] acc_q;
  logic [WIDE_W-1:0] p_u, p_w, psum_q;
  logic [DCAP_W-1:0] qcap;
  logic [WIDE_W-1:0] d_u, d_w, d_q, sum_w, sat_w;
  logic [WORD_W-1:0] sum_q;

  logic              div_busy;
  logic [PROD_W-1:0] quotient;
  logic              dt_zero;
  logic              out_valid_q;
  logic [WORD_W-1:0] drive_q, intn_q;
  logic              out_free;

  assign dt_zero  = (elapsed_q == '0);
  assign out_free = !out_valid_q || !out_stall_i;

  assign err_w = {target_q[WORD_W-1], target_q} - {measured_q[WORD_W-1], measured_q};
  assign dfb_w = {prev_q[WORD_W-1], prev_q} - {measured_q[WORD_W-1], measured_q};
  assign em_d  = err_w[MAG_W-1] ? (~err_w + {{(MAG_W-1){1'b0}}, 1'b1}) : err_w;
  assign dm_d  = dfb_w[MAG_W-1] ? (~dfb_w + {{(MAG_W-1){1'b0}}, 1'b1}) : dfb_w;

  always_comb begin
    case (cmd_i.mul_sel)
      MUL_P: begin
        op_a = mag_word(cfg_i.gain_p);
        op_b = em_q;
      end
      MUL_I: begin
        op_a = mag_word(cfg_i.gain_i);
        op_b = em_q;
      end
      MUL_ILO: begin
        op_a = mul_q[WORD_W-1:0];
        op_b = {{(MAG_W-DT_W){1'b0}}, elapsed_q};
      end
      MUL_IHI: begin
        op_a = ahi_q;
        op_b = {{(MAG_W-DT_W){1'b0}}, elapsed_q};
      end
      MUL_D: begin
        op_a = mag_word(cfg_i.gain_d);
        op_b = dm_q;
      end
      default: begin
        op_a = '0;
        op_b = '0;
      end
    endcase
  end

  // A magnitude of exactly 2^32 has all lower bits clear, so its product is a shift.
  assign prod_w = op_b[MAG_W-1] ? {op_a, {WORD_W{1'b0}}}
                                : PROD_W'(op_a) * PROD_W'(op_b[WORD_W-1:0]);

  always_comb begin
    inc_u   = {{(WIDE_W-INC_W){1'b0}}, inc_q};
    inc_w   = (cfg_i.gain_i[WORD_W-1] ^ eneg_q) ? -inc_u : inc_u;
    acc_sum = {{(WIDE_W-WORD_W){integral_q[WORD_W-1]}}, integral_q} + inc_w;
    lim_pos = {{(WIDE_W-LIM_W){1'b0}}, cfg_i.windup};
    lim_neg = -lim_pos;
    if ($signed(acc_sum) > $signed(lim_pos)) begin
      acc_cl = lim_pos;
    end else if ($signed(acc_sum) < $signed(lim_neg)) begin
      acc_cl = lim_neg;
    end else begin
      acc_cl = acc_sum;
    end
  end

  always_comb begin
    p_u = {{(WIDE_W-PMAG_W){1'b0}}, pmag_q};
    p_w = (cfg_i.gain_p[WORD_W-1] ^ eneg_q) ? -p_u : p_u;
  end

  always_comb begin
    qcap = (quotient > DCAP) ? DCAP[DCAP_W-1:0] : quotient[DCAP_W-1:0];
    d_u  = {{(WIDE_W-DCAP_W){1'b0}}, qcap};
    if (dt_zero) begin
      d_w = '0;
    end else begin
      d_w = !(cfg_i.gain_d[WORD_W-1] ^ dneg_q) ? -d_u : d_u;
    end
  end

  always_comb begin
    sum_w = psum_q + d_q;
    if ($signed(sum_w) > $signed(SAT_HI)) begin
      sat_w = SAT_HI;
    end else if ($signed(sum_w) < $signed(SAT_LO)) begin
      sat_w = SAT_LO;
    end else begin
      sat_w = sum_w;
    end
  end

  pidc_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (mul_q),
    .divisor_i  (elapsed_q),
    .busy_o     (div_busy),
    .quotient_o (quotient)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      integral_q  <= '0;
      prev_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.prep) begin
        prev_q <= measured_q;
      end
      if (cmd_i.acc_cap) begin
        integral_q <= acc_cl[WORD_W-1:0];
      end
      if (cmd_i.push) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      target_q   <= target_i;
      measured_q <= measured_i;
      elapsed_q  <= elapsed_i;
    end
    if (cmd_i.prep) begin
      em_q   <= em_d;
      eneg_q <= err_w[MAG_W-1];
      dm_q   <= dm_d;
      dneg_q <= dfb_w[MAG_W-1];
    end
    if (cmd_i.mul_en) begin
      mul_q <= prod_w;
    end
    if (cmd_i.p_cap) begin
      pmag_q <= mul_q[PROD_W-1:16];
    end
    if (cmd_i.ahi_cap) begin
      ahi_q <= mul_q[PROD_W-1:WORD_W];
    end
    if (cmd_i.lohi_cap) begin
      lohi_q <= mul_q[PROD_W-1:WORD_W];
    end
    if (cmd_i.inc_cap) begin
      inc_q <= INC_W'(mul_q) + INC_W'(lohi_q);
    end
    if (cmd_i.acc_cap) begin
      acc_q <= acc_cl[WORD_W-1:0];
    end
    if (cmd_i.psum_cap) begin
      psum_q <= p_w + {{(WIDE_W-WORD_W){acc_q[WORD_W-1]}}, acc_q};
    end
    if (cmd_i.dterm_cap) begin
      d_q <= d_w;
    end
    if (cmd_i.sum_cap) begin
      sum_q <= sat_w[WORD_W-1:0];
    end
    if (cmd_i.push) begin
      drive_q <= sum_q;
      intn_q  <= acc_q;
    end
  end

  assign sts_o.dt_zero  = dt_zero;
  assign sts_o.div_busy = div_busy;
  assign sts_o.out_free = out_free;

  assign out_valid_o    = out_valid_q;
  assign drive_o        = drive_q;
  assign integral_now_o = intn_q;

endmodule

`default_nettype wire

// ===== hdl/pidc_ctrl.sv =====
// Sequencing state machine of the PID step: steps the datapath through its multiplies,
// clamp, division and final sum. Uses pidc_pkg for the state enum and command types.
`default_nettype none

module pidc_ctrl
  import pidc_pkg::*;
(
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      in_valid_i,
  output logic           in_stall_o,
  output pidc_cmd_t      cmd_o,
  input  wire pidc_sts_t sts_i
);

  pidc_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          state_d = ST_PREP;
        end
      end
      ST_PREP:    state_d = ST_MUL_P;
      ST_MUL_P:   state_d = ST_MUL_I;
      ST_MUL_I:   state_d = ST_MUL_ILO;
      ST_MUL_ILO: state_d = ST_MUL_IHI;
      ST_MUL_IHI: state_d = ST_MUL_D;
      ST_MUL_D:   state_d = ST_ACC;
      ST_ACC:     state_d = ST_PSUM;
      ST_PSUM:    state_d = ST_WAIT;
      ST_WAIT: begin
        if (sts_i.dt_zero || !sts_i.div_busy) begin
          state_d = ST_DTERM;
        end
      end
      ST_DTERM:   state_d = ST_SUM;
      ST_SUM:     state_d = ST_FIN;
      ST_FIN: begin
        if (sts_i.out_free) begin
          state_d = ST_IDLE;
        end
      end
      default:    state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o         = '0;
    cmd_o.mul_sel = MUL_P;
    in_stall_o    = 1'b1;
    case (state_q)
      ST_IDLE: begin
        in_stall_o = 1'b0;
        cmd_o.load = in_valid_i;
      end
      ST_PREP: begin
        cmd_o.prep = 1'b1;
      end
      ST_MUL_P: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = MUL_P;
      end
      ST_MUL_I: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = MUL_I;
        cmd_o.p_cap   = 1'b1;
      end
      ST_MUL_ILO: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = MUL_ILO;
        cmd_o.ahi_cap = 1'b1;
      end
      ST_MUL_IHI: begin
        cmd_o.mul_en   = 1'b1;
        cmd_o.mul_sel  = MUL_IHI;
        cmd_o.lohi_cap = 1'b1;
      end
      ST_MUL_D: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = MUL_D;
        cmd_o.inc_cap = 1'b1;
      end
      ST_ACC: begin
        cmd_o.acc_cap   = 1'b1;
        cmd_o.div_start = !sts_i.dt_zero;
      end
      ST_PSUM: begin
        cmd_o.psum_cap = 1'b1;
      end
      ST_WAIT: begin
      end
      ST_DTERM: begin
        cmd_o.dterm_cap = 1'b1;
      end
      ST_SUM: begin
        cmd_o.sum_cap = 1'b1;
      end
      ST_FIN: begin
        cmd_o.push = sts_i.out_free;
      end
      default: begin
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== bench/pid_controller_step_tb.sv =====
`timescale 1ns / 100ps
// Self-checking bench for pid_controller_step: directed and random items under random gaps
// and stalls, results checked against a bit-exact PID predictor. Depends on pidc_pkg and pid_controller_step.

module pid_controller_step_tb;
  import pidc_pkg::*;

  localparam int WATCHDOG = 2000;
  localparam int MAX_IDLE = 18;
  localparam logic [127:0] DERIV_CAP = 128'd1 << 56;
  localparam logic signed [127:0] DRIVE_HI = 128'sh7FFF_FFFF;
  localparam logic signed [127:0] DRIVE_LO = -DRIVE_HI - 1;

  typedef struct packed {
    logic [WORD_W-1:0] target;
    logic [WORD_W-1:0] measured;
    logic [DT_W-1:0]   elapsed;
  } pid_sample_t;

  typedef struct packed {
    logic [WORD_W-1:0] drive;
    logic [WORD_W-1:0] integral_now;
  } pid_result_t;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              cfg_we_i = 1'b0;
  logic [IDX_W-1:0]  cfg_idx_i = CFG_GAIN_P;
  logic [WORD_W-1:0] cfg_data_i = '0;
  logic              in_valid_i = 1'b0;
  logic              in_stall_o;
  logic [WORD_W-1:0] target_i = '0;
  logic [WORD_W-1:0] measured_i = '0;
  logic [DT_W-1:0]   elapsed_i = '0;
  logic              out_valid_o;
  logic              out_stall_i = 1'b0;
  logic [WORD_W-1:0] drive_o;
  logic [WORD_W-1:0] integral_now_o;

  pid_sample_t pending[$];
  pid_result_t expected[$];
  pid_sample_t next_sample;

  logic signed [127:0] kp = 0;
  logic signed [127:0] ki = 0;
  logic signed [127:0] kd = 0;
  logic signed [127:0] wlim = 128'sd327680;
  logic signed [127:0] integ = 0;
  logic signed [127:0] last_meas = 0;

  logic in_fire = 1'b0;
  logic out_fire = 1'b0;
  logic idle_on = 1'b1;
  int   send_gap = 0;
  int   recv_wait = 0;
  int   idle_cycles = 0;
  int   mismatches = 0;

  pid_controller_step u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_data_i     (cfg_data_i),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .target_i       (target_i),
    .measured_i     (measured_i),
    .elapsed_i      (elapsed_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .drive_o        (drive_o),
    .integral_now_o (integral_now_o)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  function automatic logic [127:0] magnitude(input logic signed [127:0] v);
    return (v < 0) ? -v : v;
  endfunction

  function automatic logic signed [127:0] with_sign(input logic [127:0] m, input logic neg);
    return neg ? -$signed(m) : $signed(m);
  endfunction

  function automatic pid_result_t pid_predict(input logic [WORD_W-1:0] tgt_w,
                                              input logic [WORD_W-1:0] meas_w,
                                              input logic [DT_W-1:0] dt_w);
    logic signed [127:0] err, dfb, pterm, dterm, acc, total;
    logic [127:0] emag, dt, q;
    pid_result_t r;
    err = 128'($signed(tgt_w)) - 128'($signed(meas_w));
    dfb = last_meas - 128'($signed(meas_w));
    emag = magnitude(err);
    dt = 128'(dt_w);
    pterm = with_sign((magnitude(kp) * emag) >> 16, (kp < 0) != (err < 0));
    acc = integ + with_sign((magnitude(ki) * emag * dt) >> 32, (ki < 0) != (err < 0));
    if (acc > wlim) begin
      acc = wlim;
    end else if (acc < -wlim) begin
      acc = -wlim;
    end
    integ = acc;
    dterm = 0;
    if (dt != 0) begin
      q = (magnitude(kd) * magnitude(dfb)) / dt;
      if (q > DERIV_CAP) begin
        q = DERIV_CAP;
      end
      dterm = with_sign(q, (kd < 0) == (dfb < 0));
    end
    last_meas = 128'($signed(meas_w));
    total = pterm + acc + dterm;
    if (total > DRIVE_HI) begin
      total = DRIVE_HI;
    end else if (total < DRIVE_LO) begin
      total = DRIVE_LO;
    end
    r.drive = total[WORD_W-1:0];
    r.integral_now = acc[WORD_W-1:0];
    return r;
  endfunction

  function automatic logic [WORD_W-1:0] pick_word();
    case ($urandom_range(0, 7))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return 32'h0000_0000;
      3, 4: return $urandom_range(0, 32'h0004_0000) - 32'h0002_0000;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [DT_W-1:0] pick_elapsed();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return 24'hFF_FFFF;
      2, 3: return DT_W'($urandom_range(1, 24'h00_2000));
      default: return DT_W'($urandom_range(0, 24'hFF_FFFF));
    endcase
  endfunction

  task automatic add_item(input logic [WORD_W-1:0] t, input logic [WORD_W-1:0] m,
                          input logic [DT_W-1:0] e);
    pending.push_back('{target: t, measured: m, elapsed: e});
  endtask

  task automatic add_extremes();
    add_item(32'h7FFF_FFFF, 32'h8000_0000, 24'hFF_FFFF);
    add_item(32'h8000_0000, 32'h7FFF_FFFF, 24'h00_0001);
    add_item(32'h7FFF_FFFF, 32'h7FFF_FFFF, 24'h00_0000);
    add_item(32'h0000_0000, 32'h8000_0000, 24'hFF_FFFF);
    add_item(32'h8000_0000, 32'h8000_0000, 24'h00_0001);
    add_item(32'h0000_0001, 32'hFFFF_FFFF, 24'h00_0002);
    add_item(32'h0000_0000, 32'h0000_0000, 24'h80_0000);
  endtask

  // Registers change only with the block idle, so the predictor copy is updated afterwards.
  task automatic program_gains(input logic [WORD_W-1:0] p, input logic [WORD_W-1:0] i,
                               input logic [WORD_W-1:0] d, input logic [WORD_W-1:0] w);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= CFG_GAIN_P;
    cfg_data_i <= p;
    @(negedge clk_i);
    cfg_idx_i <= CFG_GAIN_I;
    cfg_data_i <= i;
    @(negedge clk_i);
    cfg_idx_i <= CFG_GAIN_D;
    cfg_data_i <= d;
    @(negedge clk_i);
    cfg_idx_i <= CFG_WINDUP;
    cfg_data_i <= w;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    kp = 128'($signed(p));
    ki = 128'($signed(i));
    kd = 128'($signed(d));
    wlim = 128'(w[LIM_W-1:0]);
  endtask

  task automatic drain();
    while (pending.size() != 0 || in_valid_i || expected.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (60) @(posedge clk_i);
  endtask

  initial begin : stimulus
    logic [WORD_W-1:0] plant, lim;
    plant = '0;
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // The windup write carries a set top bit, which the 31-bit register drops.
    program_gains(32'h0001_0000, 32'h0000_8000, 32'h0000_4000, 32'h8005_0000);
    add_item(32'h0000_0000, 32'h0000_0000, 24'h00_0000);
    add_item(32'h7FFF_FFFF, 32'h8000_0000, 24'h01_0000);
    add_item(32'h8000_0000, 32'h7FFF_FFFF, 24'h01_0000);
    add_item(32'h0000_0000, 32'h0000_0000, 24'hFF_FFFF);
    add_item(32'h000A_0000, 32'h0009_0000, 24'h00_0000);
    add_item(32'h000A_0000, 32'h0009_0000, 24'h00_0001);
    add_item(32'hFFFD_0000, 32'h0002_0000, 24'h00_0001);
    add_item(32'h0005_0000, 32'h0005_0000, 24'h00_8000);
    drain();
    program_gains(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF);
    add_extremes();
    drain();
    program_gains(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0000);
    add_extremes();
    drain();

    for (int ph = 0; ph < 8; ph++) begin
      idle_on = (ph % 4 != 1);
      case ($urandom_range(0, 3))
        0: lim = '0;
        1: lim = 32'hFFFF_FFFF;
        2: lim = $urandom_range(0, 32'h0014_0000);
        default: lim = $urandom;
      endcase
      program_gains(pick_word(), pick_word(), pick_word(), lim);
      for (int n = 0; n < 175; n++) begin
        if ($urandom_range(0, 1) == 0) begin
          plant = plant + ($urandom_range(0, 32'h0002_0000) - 32'h0001_0000);
          add_item(plant + ($urandom_range(0, 32'h0008_0000) - 32'h0004_0000), plant,
                   pick_elapsed());
        end else begin
          add_item(pick_word(), pick_word(), pick_elapsed());
        end
      end
      drain();
    end

    if (mismatches == 0 && expected.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  always @(negedge clk_i) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else if (!in_valid_i || in_fire) begin
      if (send_gap > 0) begin
        in_valid_i <= 1'b0;
        send_gap <= send_gap - 1;
      end else if (pending.size() != 0) begin
        next_sample = pending.pop_front();
        target_i <= next_sample.target;
        measured_i <= next_sample.measured;
        elapsed_i <= next_sample.elapsed;
        in_valid_i <= 1'b1;
        send_gap <= idle_on ? $urandom_range(0, MAX_IDLE) : 0;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  always @(negedge clk_i) begin
    if (out_fire) begin
      recv_wait = idle_on ? $urandom_range(0, MAX_IDLE) : 0;
    end
    out_stall_i <= (recv_wait != 0);
    if (recv_wait != 0 && out_valid_o) begin
      recv_wait = recv_wait - 1;
    end
  end

  always @(posedge clk_i) begin
    pid_result_t want;
    in_fire <= in_valid_i && !in_stall_o;
    out_fire <= out_valid_o && !out_stall_i;
    if (rst_ni && in_valid_i && !in_stall_o) begin
      expected.push_back(pid_predict(target_i, measured_i, elapsed_i));
    end
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected.size() == 0) begin
        $error("unexpected result item: drive %h integral_now %h", drive_o, integral_now_o);
        mismatches++;
      end else begin
        want = expected.pop_front();
        if (drive_o !== want.drive) begin
          $error("drive: expected %h, got %h", want.drive, drive_o);
          mismatches++;
        end
        if (integral_now_o !== want.integral_now) begin
          $error("integral_now: expected %h, got %h", want.integral_now, integral_now_o);
          mismatches++;
        end
      end
    end
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) || cfg_we_i) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG) begin
      $display("end of test: mismatches");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

endmodule

// ===== files.f =====
hdl/pidc_pkg.sv
hdl/pidc_div.sv
hdl/pidc_dp.sv
hdl/pidc_ctrl.sv
hdl/pid_controller_step.sv
bench/pid_controller_step_tb.sv
